// ----- rtl/rpgv_pkg.sv -----
// shared constants for the read path graph validator
package rpgv_pkg;

	// error kinds, ranked from highest to lowest
	localparam int NUM_ERR = 5;
	localparam int ERR_CODE_BITS = 3;

	localparam logic [ERR_CODE_BITS-1:0] ERR_NONE       = 3'd0;
	localparam logic [ERR_CODE_BITS-1:0] ERR_BAD_ID     = 3'd1;
	localparam logic [ERR_CODE_BITS-1:0] ERR_NO_LINK    = 3'd2;
	localparam logic [ERR_CODE_BITS-1:0] ERR_NEG_OFFSET = 3'd3;
	localparam logic [ERR_CODE_BITS-1:0] ERR_POS_OFFSET = 3'd4;
	localparam logic [ERR_CODE_BITS-1:0] ERR_PAST_READ  = 3'd5;

	// bit positions in the error flag vector
	localparam int FLAG_BAD_ID     = 0;
	localparam int FLAG_NO_LINK    = 1;
	localparam int FLAG_NEG_OFFSET = 2;
	localparam int FLAG_POS_OFFSET = 3;
	localparam int FLAG_PAST_READ  = 4;

	// register indexes
	localparam logic REG_KMER_SIZE  = 1'b0;
	localparam logic REG_EDGE_TOTAL = 1'b1;

	localparam logic [7:0] KMER_SIZE_RESET = 8'd48;

endpackage

// ----- rtl/rpgv_cfg.sv -----
// configuration registers behind the apb-style port
module rpgv_cfg import rpgv_pkg::*; #(
	parameter int ET_BITS   = 25,
	parameter int DATA_BITS = 32,
	parameter int ADDR_BITS = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready,
	output logic [7:0]           kmer_size,
	output logic [ET_BITS-1:0]   edge_total
);

	logic [7:0]         kmer_q;
	logic [ET_BITS-1:0] edge_total_q;
	logic               reg_idx;
	logic               wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_BITS-1];
	assign wr_en   = psel & penable & pwrite & pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_q       <= KMER_SIZE_RESET;
			edge_total_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_KMER_SIZE:  kmer_q <= pwdata[7:0];
				REG_EDGE_TOTAL: edge_total_q <= pwdata[ET_BITS-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (reg_idx)
			REG_KMER_SIZE:  prdata = DATA_BITS'(kmer_q);
			REG_EDGE_TOTAL: prdata = DATA_BITS'(edge_total_q);
			default:        prdata = '0;
		endcase
	end

	assign kmer_size  = kmer_q;
	assign edge_total = edge_total_q;

endmodule

// ----- rtl/rpgv_core.sv -----
// input register, per-edge checks, path state and result register
module rpgv_core import rpgv_pkg::*; #(
	parameter int EDGE_ID_BITS  = 24,
	parameter int EDGE_LEN_BITS = 20,
	parameter int READ_LEN_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [7:0]                 kmer_size,
	input  logic [EDGE_ID_BITS:0]      edge_total,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [EDGE_ID_BITS-1:0]    edge_ident,
	input  logic [EDGE_LEN_BITS-1:0]   edge_bases,
	input  logic [EDGE_ID_BITS-1:0]    left_vertex,
	input  logic [EDGE_ID_BITS-1:0]    right_vertex,
	input  logic [EDGE_LEN_BITS:0]     path_offset,
	input  logic [READ_LEN_BITS-1:0]   read_bases,
	input  logic                       first_edge,
	input  logic                       last_edge,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       path_ok,
	output logic [ERR_CODE_BITS-1:0]   error_code,
	output logic [EDGE_ID_BITS-1:0]    error_edge,
	output logic [EDGE_ID_BITS-1:0]    error_next_edge
);

	localparam int IDB = EDGE_ID_BITS;
	localparam int LB  = EDGE_LEN_BITS;
	localparam int RB  = READ_LEN_BITS;
	// signed working width for position arithmetic
	localparam int W   = ((LB > RB) ? LB : RB) + 3;
	localparam logic [W-1:0] SMAX_W = W'({LB{1'b1}});

	// input stage
	logic             valid_s1;
	logic [IDB-1:0]   id_s1;
	logic [LB-1:0]    len_s1;
	logic [IDB-1:0]   lv_s1;
	logic [IDB-1:0]   rv_s1;
	logic [LB:0]      off_s1;
	logic [RB-1:0]    rl_s1;
	logic             first_s1;
	logic             last_s1;

	// path state
	logic [IDB-1:0]   prev_right_q;
	logic [IDB-1:0]   prev_edge_q;
	logic [RB-1:0]    used_q;
	logic [LB-1:0]    start_q;
	logic [RB-1:0]    rl_q;
	logic [NUM_ERR-1:0] flags_q;
	logic [IDB-1:0]   err_edge_q [NUM_ERR];
	logic [IDB-1:0]   err_next_q;

	// result register
	logic                     out_valid_q;
	logic                     ok_q;
	logic [ERR_CODE_BITS-1:0] code_q;
	logic [IDB-1:0]           edge_q;
	logic [IDB-1:0]           next_q;

	logic adv;
	logic accept;

	// the stage moves on unless it holds a last edge and the result slot stays full
	assign adv      = valid_s1 & (~last_s1 | ~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | adv;
	assign accept   = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept | (valid_s1 & ~adv);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_s1    <= edge_ident;
			len_s1   <= edge_bases;
			lv_s1    <= left_vertex;
			rv_s1    <= right_vertex;
			off_s1   <= path_offset;
			rl_s1    <= read_bases;
			first_s1 <= first_edge;
			last_s1  <= last_edge;
		end
	end

	// offset decode for the first edge
	logic           off_neg;
	logic [LB:0]    neg_mag;
	logic [W-1:0]   neg_w;
	logic [W-1:0]   off_w;
	logic [W-1:0]   len_w;
	logic [W-1:0]   rl_in_w;
	logic [RB-1:0]  used_init;
	logic [LB-1:0]  start_init;

	assign off_neg    = off_s1[LB];
	assign neg_mag    = ~off_s1 + 1'b1;
	assign neg_w      = W'(neg_mag);
	assign off_w      = W'(off_s1[LB-1:0]);
	assign len_w      = W'(len_s1);
	assign rl_in_w    = W'(rl_s1);
	assign used_init  = off_neg ? ((neg_w > rl_in_w) ? rl_s1 : neg_mag[RB-1:0]) : '0;
	assign start_init = off_neg ? '0 : off_s1[LB-1:0];

	// state as seen by this edge
	logic [RB-1:0]      cur_used;
	logic [LB-1:0]      cur_start;
	logic [RB-1:0]      cur_rl;
	logic [NUM_ERR-1:0] base_flags;

	assign cur_used   = first_s1 ? used_init  : used_q;
	assign cur_start  = first_s1 ? start_init : start_q;
	assign cur_rl     = first_s1 ? rl_s1      : rl_q;
	assign base_flags = first_s1 ? '0         : flags_q;

	// checks on this edge
	logic [NUM_ERR-1:0] hit;
	logic               track;

	assign track = (cur_rl != '0) & ~base_flags[FLAG_PAST_READ];

	always_comb begin
		hit = '0;
		hit[FLAG_BAD_ID]     = ({1'b0, id_s1} >= edge_total);
		hit[FLAG_NO_LINK]    = ~first_s1 & (lv_s1 != prev_right_q);
		hit[FLAG_NEG_OFFSET] = first_s1 & (rl_s1 != '0) & off_neg & (neg_w >= rl_in_w);
		hit[FLAG_POS_OFFSET] = first_s1 & ~off_neg & (off_w >= len_w);
		hit[FLAG_PAST_READ]  = track & (cur_used >= cur_rl);
	end

	// position tracking with k-1 overlap trimming
	logic [W-1:0]        used_w;
	logic [W-1:0]        start_w;
	logic [W-1:0]        km1;
	logic [W-1:0]        rem;
	logic [W-1:0]        trimmed;
	logic [W-1:0]        endp0;
	logic [W-1:0]        endp1;
	logic [W-1:0]        endp;
	logic [W-1:0]        used_sum;
	logic [W-1:0]        sp_raw;
	logic [LB-1:0]       sp_next;
	logic                step_pos;

	assign used_w   = W'(cur_used);
	assign start_w  = W'(cur_start);
	assign km1      = W'(kmer_size) - W'(1);
	assign rem      = W'(cur_rl) - used_w;
	assign trimmed  = len_w - (last_s1 ? '0 : km1);
	assign endp0    = start_w + rem;
	assign endp1    = ($signed(endp0) > $signed(trimmed)) ? trimmed : endp0;
	assign endp     = ($signed(start_w) >= $signed(endp1)) ? start_w : endp1;
	assign used_sum = used_w + (endp - start_w);
	assign sp_raw   = (start_w == endp) ? (km1 - len_w + start_w) : '0;
	assign step_pos = track & ~hit[FLAG_PAST_READ];

	// clamp the next start position to its range
	always_comb begin
		if ($signed(sp_raw) < 0) begin
			sp_next = '0;
		end else if ($signed(sp_raw) > $signed(SMAX_W)) begin
			sp_next = {LB{1'b1}};
		end else begin
			sp_next = sp_raw[LB-1:0];
		end
	end

	// merged error record, earliest occurrence per kind kept
	logic [NUM_ERR-1:0] new_flags;
	logic [IDB-1:0]     hit_edge [NUM_ERR];
	logic [IDB-1:0]     edge_v   [NUM_ERR];
	logic [IDB-1:0]     next_v;

	assign new_flags = base_flags | hit;
	assign next_v    = base_flags[FLAG_NO_LINK] ? err_next_q : id_s1;

	always_comb begin
		for (int k = 0; k < NUM_ERR; k++) begin
			hit_edge[k] = id_s1;
		end
		hit_edge[FLAG_NO_LINK] = prev_edge_q;
		for (int k = 0; k < NUM_ERR; k++) begin
			edge_v[k] = base_flags[k] ? err_edge_q[k] : hit_edge[k];
		end
	end

	// pick the highest-ranked error
	logic [ERR_CODE_BITS-1:0] res_code;
	logic [IDB-1:0]           res_edge;
	logic [IDB-1:0]           res_next;

	always_comb begin
		res_code = ERR_NONE;
		res_edge = '0;
		res_next = '0;
		for (int k = NUM_ERR - 1; k >= 0; k--) begin
			if (new_flags[k]) begin
				res_code = ERR_CODE_BITS'(k + 1);
				res_edge = edge_v[k];
			end
		end
		if (res_code == ERR_NO_LINK) begin
			res_next = next_v;
		end
	end

	// path state update, cleared after a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_right_q <= '0;
			prev_edge_q  <= '0;
			used_q       <= '0;
			start_q      <= '0;
			rl_q         <= '0;
			flags_q      <= '0;
		end else if (adv) begin
			if (last_s1) begin
				prev_right_q <= '0;
				prev_edge_q  <= '0;
				used_q       <= '0;
				start_q      <= '0;
				rl_q         <= '0;
				flags_q      <= '0;
			end else begin
				prev_right_q <= rv_s1;
				prev_edge_q  <= id_s1;
				used_q       <= step_pos ? used_sum[RB-1:0] : cur_used;
				start_q      <= step_pos ? sp_next : cur_start;
				rl_q         <= cur_rl;
				flags_q      <= new_flags;
			end
		end
	end

	// error id records
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NUM_ERR; k++) begin
				err_edge_q[k] <= edge_v[k];
			end
			err_next_q <= next_v;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv & last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv & last_s1) begin
			ok_q   <= (new_flags == '0);
			code_q <= res_code;
			edge_q <= res_edge;
			next_q <= res_next;
		end
	end

	assign out_valid       = out_valid_q;
	assign path_ok         = ok_q;
	assign error_code      = code_q;
	assign error_edge      = edge_q;
	assign error_next_edge = next_q;

endmodule

// ----- rtl/read_path_graph_validator.sv -----
// top level of the read path graph validator
//
//  channel  dir  handshake          payload
//  s_*      in   tvalid / tready    tdata edge fields, tuser first_edge, tlast last_edge
//  m_*      out  tvalid / tready    tdata path_ok, error_code, error_edge, error_next_edge
//  apb      in   psel / penable     kmer_size at 0x0, edge_total at 0x4
//
// one edge item is taken per cycle while the input side does not stall; the path
// state update (a few adds and compares between the input register and the state
// registers) is combinational
// a result is registered when its last edge leaves the input register
// the input side stalls only when a last edge waits for a full result register
// reset clears path state and the error flags; kmer_size resets to 48, edge_total to 0
module read_path_graph_validator import rpgv_pkg::*; #(
	parameter int EDGE_ID_BITS  = 24,
	parameter int EDGE_LEN_BITS = 20,
	parameter int READ_LEN_BITS = 16,
	localparam int ET_BITS   = EDGE_ID_BITS + 1,
	localparam int DATA_BITS = (ET_BITS > 32) ? 64 : 32,
	localparam int ADDR_BITS = (ET_BITS > 32) ? 4 : 3,
	localparam int IN_BITS   = 3 * EDGE_ID_BITS + 2 * EDGE_LEN_BITS + 1 + READ_LEN_BITS,
	localparam int IN_DATA   = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS  = 1 + ERR_CODE_BITS + 2 * EDGE_ID_BITS,
	localparam int OUT_DATA  = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// edge_ident, edge_bases, left_vertex, right_vertex, path_offset, read_bases
	input  logic [IN_DATA-1:0]   s_tdata,
	// first_edge
	input  logic                 s_tuser,
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// path_ok, error_code, error_edge, error_next_edge
	output logic [OUT_DATA-1:0]  m_tdata
);

	localparam int O_BASES = EDGE_ID_BITS;
	localparam int O_LV    = O_BASES + EDGE_LEN_BITS;
	localparam int O_RV    = O_LV + EDGE_ID_BITS;
	localparam int O_OFF   = O_RV + EDGE_ID_BITS;
	localparam int O_RL    = O_OFF + EDGE_LEN_BITS + 1;

	logic [7:0]                kmer_size;
	logic [ET_BITS-1:0]        edge_total;
	logic                      path_ok;
	logic [ERR_CODE_BITS-1:0]  error_code;
	logic [EDGE_ID_BITS-1:0]   error_edge;
	logic [EDGE_ID_BITS-1:0]   error_next_edge;

	rpgv_cfg #(
		.ET_BITS   (ET_BITS),
		.DATA_BITS (DATA_BITS),
		.ADDR_BITS (ADDR_BITS)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.kmer_size  (kmer_size),
		.edge_total (edge_total)
	);

	rpgv_core #(
		.EDGE_ID_BITS  (EDGE_ID_BITS),
		.EDGE_LEN_BITS (EDGE_LEN_BITS),
		.READ_LEN_BITS (READ_LEN_BITS)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.kmer_size       (kmer_size),
		.edge_total      (edge_total),
		.in_valid        (s_tvalid),
		.in_ready        (s_tready),
		.edge_ident      (s_tdata[0 +: EDGE_ID_BITS]),
		.edge_bases      (s_tdata[O_BASES +: EDGE_LEN_BITS]),
		.left_vertex     (s_tdata[O_LV +: EDGE_ID_BITS]),
		.right_vertex    (s_tdata[O_RV +: EDGE_ID_BITS]),
		.path_offset     (s_tdata[O_OFF +: EDGE_LEN_BITS + 1]),
		.read_bases      (s_tdata[O_RL +: READ_LEN_BITS]),
		.first_edge      (s_tuser),
		.last_edge       (s_tlast),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.path_ok         (path_ok),
		.error_code      (error_code),
		.error_edge      (error_edge),
		.error_next_edge (error_next_edge)
	);

	// pack the result item, first field in the low bits
	assign m_tdata = OUT_DATA'({error_next_edge, error_edge, error_code, path_ok});

endmodule

// ----- rtl/rpgv_checker.sv -----
// port-level checks on the read path graph validator, bound to its top level
module rpgv_checker import rpgv_pkg::*; #(
	parameter int EDGE_ID_BITS = 24,
	parameter int OUT_DATA     = 56
) (
	input logic                clk,
	input logic                arst_n,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [OUT_DATA-1:0] m_tdata
);

	localparam int O_EDGE = 1 + ERR_CODE_BITS;
	localparam int O_NEXT = O_EDGE + EDGE_ID_BITS;

	logic                     ok;
	logic [ERR_CODE_BITS-1:0] code;
	logic [EDGE_ID_BITS-1:0]  err_edge;
	logic [EDGE_ID_BITS-1:0]  err_next;

	assign ok       = m_tdata[0];
	assign code     = m_tdata[1 +: ERR_CODE_BITS];
	assign err_edge = m_tdata[O_EDGE +: EDGE_ID_BITS];
	assign err_next = m_tdata[O_NEXT +: EDGE_ID_BITS];

	// a held result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a passing path names no error and no edges
	a_ok_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ok |-> code == ERR_NONE && err_edge == '0 && err_next == '0)
		else $error("ok result carries error data");

	// a failing path carries a defined error code
	a_fail_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !ok |-> code == ERR_BAD_ID || code == ERR_NO_LINK ||
			code == ERR_NEG_OFFSET || code == ERR_POS_OFFSET || code == ERR_PAST_READ)
		else $error("failing result without a valid code");

	// only a connection error names a following edge
	a_next_edge: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && code != ERR_NO_LINK |-> err_next == '0)
		else $error("following edge set outside a connection error");

	// with the result slot empty the input side never stalls
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty result slot");

endmodule

bind read_path_graph_validator rpgv_checker #(
	.EDGE_ID_BITS (EDGE_ID_BITS),
	.OUT_DATA     (OUT_DATA)
) u_rpgv_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- tb/sv/tb_top.sv -----
// self-checking stream testbench for read_path_graph_validator
module tb_top import rpgv_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ID_W    = 24;
	localparam int LEN_W   = 20;
	localparam int RLEN_W  = 16;
	localparam int IN_W    = 136;
	localparam int OUT_W   = 56;
	localparam longint POS_MAX = (64'd1 << LEN_W) - 1;
	localparam int OFF_LOW = -65535;
	localparam int OFF_HIGH = 1048575;
	localparam logic [LEN_W-1:0] BASES_MAX = '1;
	localparam logic [ID_W-1:0] IDENT_MAX = '1;

	// flag slot to reported code, highest rank first
	localparam logic [ERR_CODE_BITS-1:0] SLOT_CODE [NUM_ERR] = '{
		ERR_BAD_ID, ERR_NO_LINK, ERR_NEG_OFFSET, ERR_POS_OFFSET, ERR_PAST_READ
	};

	typedef struct {
		logic [ID_W-1:0]   ident;
		logic [LEN_W-1:0]  bases;
		logic [ID_W-1:0]   lvert;
		logic [ID_W-1:0]   rvert;
		int                offset;
		logic [RLEN_W-1:0] rlen;
		bit                is_first;
		bit                is_last;
	} edge_item_t;

	// laid out as on m_tdata, path_ok in bit 0
	typedef struct packed {
		logic [ID_W-1:0]          edge_b;
		logic [ID_W-1:0]          edge_a;
		logic [ERR_CODE_BITS-1:0] code;
		logic                     ok;
	} verdict_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             psel = 1'b0;
	logic             penable = 1'b0;
	logic             pwrite = 1'b0;
	logic [2:0]       paddr = '0;
	logic [31:0]      pwdata = '0;
	logic [31:0]      prdata;
	logic             pready;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	// edge_ident, edge_bases, left_vertex, right_vertex, path_offset, read_bases
	logic [IN_W-1:0]  s_tdata = '0;
	// first_edge
	logic             s_tuser = 1'b0;
	logic             s_tlast = 1'b0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	// path_ok, error_code, error_edge, error_next_edge
	logic [OUT_W-1:0] m_tdata;

	read_path_graph_validator u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// register mirror
	logic [7:0]  kmer_cfg = KMER_SIZE_RESET;
	logic [24:0] total_cfg = '0;

	// path tracking state
	logic [ID_W-1:0] trk_prev_right;
	logic [ID_W-1:0] trk_prev_edge;
	longint          trk_used;
	longint          trk_start;
	longint          trk_read_len;
	logic [NUM_ERR-1:0] trk_flags;
	logic [ID_W-1:0] trk_err_a [NUM_ERR];
	logic [ID_W-1:0] trk_err_b [NUM_ERR];

	edge_item_t edge_queue [$];
	verdict_t   verdict_q [$];
	edge_item_t edge_live;

	int cyc = 0;
	int edges_taken = 0;
	int paths_checked = 0;
	int mismatches = 0;
	int code_seen [6];
	int hold_left = 0;
	bit hold_done = 1'b0;
	bit quiet_window;

	assign quiet_window = (cyc >= 1200) && (cyc < 2000);

	always @(posedge clk) cyc <= cyc + 1;

	function automatic void clear_track();
		trk_prev_right = '0;
		trk_prev_edge = '0;
		trk_used = 0;
		trk_start = 0;
		trk_read_len = 0;
		trk_flags = '0;
		for (int i = 0; i < NUM_ERR; i++) begin
			trk_err_a[i] = '0;
			trk_err_b[i] = '0;
		end
	endfunction

	// keep only the first occurrence of each error kind
	function automatic void log_fault(int slot, logic [ID_W-1:0] a, logic [ID_W-1:0] b);
		if (!trk_flags[slot]) begin
			trk_flags[slot] = 1'b1;
			trk_err_a[slot] = a;
			trk_err_b[slot] = b;
		end
	endfunction

	// advance the path state by one accepted edge, queue a verdict on the last one
	function automatic void trace_edge(edge_item_t e);
		longint len, off, rl, km1, rem, trimmed, endp;
		verdict_t v;
		bit found;
		len = longint'(e.bases);
		off = longint'(e.offset);
		rl = longint'(e.rlen);
		km1 = longint'(kmer_cfg) - 1;
		if (e.is_first) begin
			for (int i = 0; i < NUM_ERR; i++) begin
				trk_err_a[i] = '0;
				trk_err_b[i] = '0;
			end
			trk_flags = '0;
			trk_read_len = rl;
			trk_used = (off < 0) ? -off : 0;
			if (trk_used > rl)
				trk_used = rl;
			trk_start = (off < 0) ? 0 : off;
			if (rl != 0 && off < 0 && -off >= rl)
				log_fault(FLAG_NEG_OFFSET, e.ident, '0);
			if (off >= 0 && off >= len)
				log_fault(FLAG_POS_OFFSET, e.ident, '0);
		end
		if ({1'b0, e.ident} >= total_cfg)
			log_fault(FLAG_BAD_ID, e.ident, '0);
		if (!e.is_first && e.lvert != trk_prev_right)
			log_fault(FLAG_NO_LINK, trk_prev_edge, e.ident);
		// consume read bases, trimming the k-1 overlap on all but the last edge
		if (trk_read_len != 0 && !trk_flags[FLAG_PAST_READ]) begin
			rem = trk_read_len - trk_used;
			if (rem <= 0) begin
				log_fault(FLAG_PAST_READ, e.ident, '0);
			end else begin
				trimmed = len - (e.is_last ? 0 : km1);
				endp = trk_start + rem;
				if (endp > trimmed)
					endp = trimmed;
				if (trk_start >= endp)
					endp = trk_start;
				trk_used += endp - trk_start;
				if (trk_start == endp)
					trk_start = km1 - (len - trk_start);
				else
					trk_start = 0;
				if (trk_start < 0)
					trk_start = 0;
				if (trk_start > POS_MAX)
					trk_start = POS_MAX;
			end
		end
		trk_prev_right = e.rvert;
		trk_prev_edge = e.ident;
		if (e.is_last) begin
			v = '{ok: 1'b1, code: ERR_NONE, edge_a: '0, edge_b: '0};
			found = 1'b0;
			for (int i = 0; i < NUM_ERR; i++) begin
				if (trk_flags[i] && !found) begin
					found = 1'b1;
					v = '{ok: 1'b0, code: SLOT_CODE[i], edge_a: trk_err_a[i],
						edge_b: trk_err_b[i]};
				end
			end
			verdict_q.insert(verdict_q.size(), v);
			clear_track();
		end
	endfunction

	// driver: offers queued edge items, idling at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			s_tlast <= 1'b0;
			clear_track();
		end else begin
			if (s_tvalid && s_tready) begin
				trace_edge(edge_live);
				edges_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (edge_queue.size() > 0 && (quiet_window || $urandom_range(99) >= 35)) begin
					edge_live = edge_queue.pop_front();
					s_tdata <= {7'd0, edge_live.rlen, edge_live.offset[20:0], edge_live.rvert,
						edge_live.lvert, edge_live.bases, edge_live.ident};
					s_tuser <= edge_live.is_first;
					s_tlast <= edge_live.is_last;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each path result against the oldest expected verdict
	always @(posedge clk or negedge arst_n) begin
		verdict_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[51:0];
				if (verdict_q.size() == 0) begin
					$display("%0t: result expected none actual %h", $time, got);
					mismatches++;
				end else begin
					want = verdict_q.pop_front();
					if (got.ok !== want.ok) begin
						$display("%0t: path_ok expected %0d actual %0d", $time, want.ok, got.ok);
						mismatches++;
					end
					if (got.code !== want.code) begin
						$display("%0t: error_code expected %0d actual %0d",
							$time, want.code, got.code);
						mismatches++;
					end
					if (got.edge_a !== want.edge_a) begin
						$display("%0t: error_edge expected %h actual %h",
							$time, want.edge_a, got.edge_a);
						mismatches++;
					end
					if (got.edge_b !== want.edge_b) begin
						$display("%0t: error_next_edge expected %h actual %h",
							$time, want.edge_b, got.edge_b);
						mismatches++;
					end
					if (want.code <= ERR_PAST_READ)
						code_seen[want.code]++;
				end
				paths_checked++;
			end
			// one long hold-off once the run is under way
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
			end else if (!hold_done && paths_checked >= 150) begin
				hold_left <= 400;
				hold_done <= 1'b1;
			end
			m_tready <= (hold_left == 0) && (quiet_window || $urandom_range(99) >= 35);
		end
	end

	task automatic reg_write(input logic idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_KMER_SIZE)
			kmer_cfg = value[7:0];
		else
			total_cfg = value[24:0];
		@(negedge clk);
	endtask

	// wait until every queued item is taken and every verdict has come back
	task automatic wait_drained();
		@(negedge clk);
		while (edge_queue.size() != 0 || s_tvalid || verdict_q.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic add_edge(input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len,
			input logic [ID_W-1:0] lv, input logic [ID_W-1:0] rv, input int off,
			input logic [RLEN_W-1:0] rl, input bit fm, input bit lm);
		edge_item_t e;
		e = '{ident: id, bases: len, lvert: lv, rvert: rv, offset: off, rlen: rl,
			is_first: fm, is_last: lm};
		edge_queue.insert(edge_queue.size(), e);
	endtask

	function automatic logic [ID_W-1:0] pick_ident();
		int r;
		r = $urandom_range(99);
		if (total_cfg == 0 || r < 2)
			return ID_W'($urandom());
		if (r < 90)
			return ID_W'($urandom_range(total_cfg - 1, 0));
		if (total_cfg <= IDENT_MAX)
			return ID_W'($urandom_range(IDENT_MAX, total_cfg));
		return ID_W'($urandom());
	endfunction

	function automatic logic [LEN_W-1:0] pick_bases();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return LEN_W'($urandom_range(2 * kmer_cfg + 60, 1));
		if (r < 90)
			return LEN_W'($urandom_range(4000, 1));
		if (r < 97)
			return LEN_W'($urandom_range(BASES_MAX, 1));
		return BASES_MAX;
	endfunction

	function automatic logic [RLEN_W-1:0] pick_read_len();
		int r;
		r = $urandom_range(99);
		if (r < 20)
			return '0;
		if (r < 80)
			return RLEN_W'($urandom_range(600, 1));
		if (r < 95)
			return RLEN_W'($urandom_range(65535, 1));
		return '1;
	endfunction

	function automatic int pick_offset(int len, int rl);
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return $urandom_range(len - 1, 0);
		if (r < 65)
			return (len + 50 > OFF_HIGH) ? OFF_HIGH : $urandom_range(len + 50, len);
		if (r < 80)
			return -$urandom_range((rl > 0) ? rl + 5 : 200, 1);
		if (r < 85)
			return OFF_LOW;
		if (r < 90)
			return OFF_HIGH;
		return $urandom_range(OFF_HIGH - OFF_LOW, 0) + OFF_LOW;
	endfunction

	// one path: mostly joined edges, with broken joins and dropped marks as noise
	task automatic gen_path(output int made);
		int n;
		int off;
		logic [ID_W-1:0] lv, rv;
		logic [LEN_W-1:0] len;
		logic [RLEN_W-1:0] rl;
		bit fm, lm;
		n = ($urandom_range(99) < 20) ? 1 : $urandom_range(8, 2);
		rl = pick_read_len();
		lv = ID_W'($urandom());
		for (int i = 0; i < n; i++) begin
			len = pick_bases();
			if (i > 0 && $urandom_range(99) < 8)
				lv = ID_W'($urandom());
			rv = ID_W'($urandom());
			if (i == 0)
				off = pick_offset(len, rl);
			else
				off = ($urandom_range(99) < 30) ?
					$urandom_range(OFF_HIGH - OFF_LOW, 0) + OFF_LOW : 0;
			fm = (i == 0) && ($urandom_range(99) >= 4);
			lm = (i == n - 1) && ($urandom_range(99) >= 4);
			add_edge(pick_ident(), len, lv, rv, off,
				(i == 0 || $urandom_range(99) < 30) ? rl : pick_read_len(), fm, lm);
			lv = rv;
		end
		made = n;
	endtask

	task automatic run_phase(input logic [7:0] kmer, input logic [24:0] total,
			input int count, input bit pause_mid);
		int made, step;
		wait_drained();
		reg_write(REG_KMER_SIZE, {24'd0, kmer});
		reg_write(REG_EDGE_TOTAL, {7'd0, total});
		made = 0;
		while (made < count) begin
			gen_path(step);
			made += step;
			// sender holds back until every result so far has come
			if (pause_mid && made >= count / 2 && made - step < count / 2)
				wait_drained();
		end
	endtask

	// stimulus
	initial begin
		for (int i = 0; i < 6; i++)
			code_seen[i] = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed paths
		wait_drained();
		reg_write(REG_KMER_SIZE, 32'd31);
		reg_write(REG_EDGE_TOTAL, 32'd1000);
		add_edge(24'd5, 20'd100, 24'd0, 24'd11, 0, 16'd50, 1, 1);
		add_edge(IDENT_MAX, BASES_MAX, IDENT_MAX, IDENT_MAX, OFF_HIGH, 16'hFFFF, 1, 1);
		add_edge(24'd0, 20'd1, 24'd0, 24'd0, 0, 16'd0, 1, 1);
		// broken join inside a path
		add_edge(24'd10, 20'd300, 24'd1, 24'd7, 5, 16'd0, 1, 0);
		add_edge(24'd11, 20'd300, 24'd8, 24'd9, 0, 16'd0, 0, 1);
		// negative offsets at and beyond the read length
		add_edge(24'd20, 20'd500, 24'd0, 24'd3, OFF_LOW, 16'd100, 1, 1);
		add_edge(24'd21, 20'd500, 24'd0, 24'd3, -100, 16'd100, 1, 1);
		// offset equal to the first edge length
		add_edge(24'd22, 20'd200, 24'd0, 24'd3, 200, 16'd0, 1, 1);
		// read runs out before the path ends
		add_edge(24'd30, 20'd100, 24'd0, 24'd1, 0, 16'd10, 1, 0);
		add_edge(24'd31, 20'd100, 24'd1, 24'd2, 0, 16'd0, 0, 0);
		add_edge(24'd32, 20'd100, 24'd2, 24'd3, 0, 16'd0, 0, 1);
		// no first mark, continuing the cleared state
		add_edge(24'd40, 20'd100, 24'd0, 24'd5, 0, 16'd0, 0, 0);
		add_edge(24'd41, 20'd100, 24'd5, 24'd6, 0, 16'd0, 0, 1);
		add_edge(24'd42, 20'd100, 24'd9, 24'd1, 0, 16'd0, 0, 1);
		// bad id outranks an earlier broken join
		add_edge(24'd50, 20'd200, 24'd0, 24'd4, 0, 16'd0, 1, 0);
		add_edge(24'd51, 20'd200, 24'd99, 24'd5, 0, 16'd0, 0, 0);
		add_edge(24'd2000, 20'd200, 24'd5, 24'd6, 0, 16'd0, 0, 1);
		// unknown read length over several edges
		add_edge(24'd60, 20'd100, 24'd0, 24'd1, 50, 16'd0, 1, 0);
		add_edge(24'd61, 20'd100, 24'd1, 24'd2, 0, 16'd0, 0, 0);
		add_edge(24'd62, 20'd100, 24'd2, 24'd3, 0, 16'd0, 0, 1);
		// negative offset inside the read, then the read is used up
		add_edge(24'd70, 20'd50, 24'd0, 24'd1, -20, 16'd40, 1, 0);
		add_edge(24'd71, 20'd60, 24'd1, 24'd2, 0, 16'd0, 0, 1);

		// random paths under several register settings
		run_phase(8'd2, 25'd16777216, 350, 1'b0);
		run_phase(8'd255, 25'd0, 150, 1'b0);
		run_phase(8'd48, 25'd5000, 350, 1'b1);
		run_phase(8'd100, 25'd16777215, 300, 1'b0);
		run_phase(8'd17, 25'd1048576, 300, 1'b0);

		wait_drained();
		repeat (10) @(negedge clk);
		$display("tb_top: %0d edge items, %0d path results, %0d mismatches",
			edges_taken, paths_checked, mismatches);
		$display("tb_top: results by code ok/id/link/neg/pos/read = %0d/%0d/%0d/%0d/%0d/%0d",
			code_seen[0], code_seen[1], code_seen[2], code_seen[3], code_seen[4], code_seen[5]);
		if (mismatches == 0 && verdict_q.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
